@@ sv/m3i_pkg.sv @@
// shared types and constants for the 3x3 matrix inverse
// no dependencies
package m3i_pkg;

  localparam int THR_W = 17;
  localparam logic [THR_W-1:0] THR_RESET = 17'd1;

  // cofactor k = e[p0]*e[p1] - e[p2]*e[p3], column-major element order
  localparam int COF_IDX [9][4] = '{
    '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };

  typedef struct packed {
    logic valid;
    logic singular;
  } ctrl_t;

endpackage

@@ sv/m3i_front.sv @@
// cofactor and determinant pipeline, six stages, ends in magnitudes and signs
// depends on m3i_pkg
module m3i_front #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_req,
  input  logic signed [W-1:0]     elem [9],
  input  logic [m3i_pkg::THR_W-1:0] thr,
  output m3i_pkg::ctrl_t          ctrl,
  output logic [2*W:0]            cof_mag [9],
  output logic                    cof_neg [9],
  output logic [3*W+2:0]          det_mag,
  output logic                    det_neg
);

  localparam int CFW = 2 * W + 1;
  localparam int DTW = 3 * W + 3;

  logic                  v [5];
  logic signed [W-1:0]   ea [9];
  logic signed [2*W-1:0] pb [18];
  logic signed [W-1:0]   eb [3];
  logic signed [CFW-1:0] cc [9];
  logic signed [W-1:0]   ec [3];
  logic signed [2*W:0]   pl [3];
  logic signed [2*W:0]   ph [3];
  logic signed [CFW-1:0] cd [9];
  logic signed [DTW-1:0] det;
  logic signed [CFW-1:0] ce [9];

  function automatic logic [DTW-1:0] det_mag_w();
    return det[DTW-1] ? (~det + 1'b1) : det;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 5; i++) v[i] <= 1'b0;
      ctrl <= '0;
    end else if (en) begin
      v[0] <= in_req;
      for (int i = 1; i < 5; i++) v[i] <= v[i-1];
      ctrl.valid <= v[4];
      ctrl.singular <= (det_mag_w() >> (2 * F)) <= thr;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ea <= elem;
      for (int k = 0; k < 9; k++) begin
        pb[2*k]   <= ea[m3i_pkg::COF_IDX[k][0]] * ea[m3i_pkg::COF_IDX[k][1]];
        pb[2*k+1] <= ea[m3i_pkg::COF_IDX[k][2]] * ea[m3i_pkg::COF_IDX[k][3]];
      end
      eb[0] <= ea[0];
      eb[1] <= ea[3];
      eb[2] <= ea[6];
      for (int k = 0; k < 9; k++) cc[k] <= CFW'(pb[2*k]) - CFW'(pb[2*k+1]);
      ec <= eb;
      for (int j = 0; j < 3; j++) begin
        pl[j] <= ec[j] * $signed({1'b0, cc[j][W-1:0]});
        ph[j] <= ec[j] * $signed(cc[j][CFW-1:W]);
      end
      cd <= cc;
      det <= (DTW'(ph[0]) <<< W) + DTW'(pl[0]) + (DTW'(ph[1]) <<< W) + DTW'(pl[1])
           + (DTW'(ph[2]) <<< W) + DTW'(pl[2]);
      ce <= cd;
      for (int k = 0; k < 9; k++) begin
        cof_mag[k] <= ce[k][CFW-1] ? (~ce[k] + 1'b1) : ce[k];
        cof_neg[k] <= ce[k][CFW-1];
      end
      det_mag <= det_mag_w();
      det_neg <= det[DTW-1];
    end
  end

endmodule

@@ sv/m3i_div_lane.sv @@
// one divider lane: adjugate element over determinant, one quotient bit a stage,
// then sign and saturation; depends on m3i_pkg
module m3i_div_lane #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  m3i_pkg::ctrl_t ctrl_in,
  input  logic [2*W:0]   cof_mag,
  input  logic           cof_neg,
  input  logic [3*W+2:0] det_mag,
  input  logic           det_neg,
  output m3i_pkg::ctrl_t ctrl_out,
  output logic [W-1:0]   val,
  output logic           sat
);

  localparam int CW = 2 * W + 1;
  localparam int DW = 3 * W + 3;
  localparam int NW = CW + 2 * F;
  localparam int RW = (DW + W > NW) ? DW + W : NW;
  localparam logic [W-1:0] HALF = {1'b1, {(W-1){1'b0}}};

  logic [RW-1:0]  rem [W+1];
  logic [RW-1:0]  den [W+1];
  logic [W-1:0]   q   [W+1];
  logic           neg [W+1];
  logic           ovf [W+1];
  m3i_pkg::ctrl_t ctl [W+1];

  logic [RW-1:0] num_w;
  logic [RW-1:0] den_w;
  assign num_w = RW'(cof_mag) << (2 * F);
  assign den_w = RW'(det_mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl[0] <= '0;
    end else if (en) begin
      ctl[0] <= ctrl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num_w;
      den[0] <= den_w;
      q[0]   <= '0;
      neg[0] <= cof_neg ^ det_neg;
      ovf[0] <= num_w >= (den_w << W);
    end
  end

  for (genvar k = 1; k <= W; k++) begin : g_step
    logic [RW-1:0] trial;
    logic          take;
    assign trial = den[k-1] << (W - k);
    assign take  = rem[k-1] >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[k] <= '0;
      end else if (en) begin
        ctl[k] <= ctl[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= take ? rem[k-1] - trial : rem[k-1];
        den[k] <= den[k-1];
        q[k]   <= q[k-1] | (W'(take) << (W - k));
        neg[k] <= neg[k-1];
        ovf[k] <= ovf[k-1];
      end
    end
  end

  logic         neg_f;
  logic         sat_f;
  assign neg_f = neg[W] && (ovf[W] || q[W] != '0);
  assign sat_f = ovf[W] || (neg_f ? (q[W] > HALF) : (q[W] > HALF - 1'b1));

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out <= '0;
    end else if (en) begin
      ctrl_out <= ctl[W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sat <= sat_f;
      if (sat_f) val <= neg_f ? HALF : HALF - 1'b1;
      else       val <= neg_f ? (~q[W] + 1'b1) : q[W];
    end
  end

endmodule

@@ sv/matrix3_inverse_top.sv @@
// 3x3 matrix inverse by adjugate: cofactor front end, nine divider lanes, merge
// depends on m3i_pkg, m3i_front, m3i_div_lane
//
//   channel  | handshake          | payload
//   ---------+--------------------+-----------------------------------------
//   input    | in_valid, in_stall | a_r0c0 .. a_r2c2
//   output   | out_valid,out_stall| inv_r0c0 .. inv_r2c2, singular, saturated
//   config   | wr_en              | wr_data (threshold)
//
// one matrix enters every cycle while the output is not stalled; the stages are:
// six front stages, ELEM_WIDTH + 2 stages in each divider lane, one merge register
// the divider lanes, one quotient bit per stage, set the depth
// reset clears all valid bits and sets the threshold to 1
// an output stall while out_valid is high freezes the whole pipeline and raises in_stall
module matrix3_inverse_top #(
  parameter int ELEM_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [ELEM_WIDTH-1:0] a_r0c0,
  input  logic signed [ELEM_WIDTH-1:0] a_r1c0,
  input  logic signed [ELEM_WIDTH-1:0] a_r2c0,
  input  logic signed [ELEM_WIDTH-1:0] a_r0c1,
  input  logic signed [ELEM_WIDTH-1:0] a_r1c1,
  input  logic signed [ELEM_WIDTH-1:0] a_r2c1,
  input  logic signed [ELEM_WIDTH-1:0] a_r0c2,
  input  logic signed [ELEM_WIDTH-1:0] a_r1c2,
  input  logic signed [ELEM_WIDTH-1:0] a_r2c2,
  input  logic                         wr_en,
  input  logic [m3i_pkg::THR_W-1:0]    wr_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [ELEM_WIDTH-1:0] inv_r0c0,
  output logic signed [ELEM_WIDTH-1:0] inv_r1c0,
  output logic signed [ELEM_WIDTH-1:0] inv_r2c0,
  output logic signed [ELEM_WIDTH-1:0] inv_r0c1,
  output logic signed [ELEM_WIDTH-1:0] inv_r1c1,
  output logic signed [ELEM_WIDTH-1:0] inv_r2c1,
  output logic signed [ELEM_WIDTH-1:0] inv_r0c2,
  output logic signed [ELEM_WIDTH-1:0] inv_r1c2,
  output logic signed [ELEM_WIDTH-1:0] inv_r2c2,
  output logic                         singular,
  output logic                         saturated
);

  localparam int W = ELEM_WIDTH;

  logic                      en;
  logic [m3i_pkg::THR_W-1:0] thr;
  logic signed [W-1:0]       elem [9];
  m3i_pkg::ctrl_t            fctrl;
  logic [2*W:0]              cof_mag [9];
  logic                      cof_neg [9];
  logic [3*W+2:0]            det_mag;
  logic                      det_neg;
  m3i_pkg::ctrl_t            lctrl;
  logic [W-1:0]              lval [9];
  logic                      lsat [9];
  logic [W-1:0]              res  [9];

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  assign elem = '{a_r0c0, a_r1c0, a_r2c0, a_r0c1, a_r1c1, a_r2c1, a_r0c2, a_r1c2, a_r2c2};

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= m3i_pkg::THR_RESET;
    end else if (wr_en) begin
      thr <= wr_data;
    end
  end

  m3i_front #(.W(W), .F(FRAC_BITS)) u_front (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_req  (in_valid),
    .elem    (elem),
    .thr     (thr),
    .ctrl    (fctrl),
    .cof_mag (cof_mag),
    .cof_neg (cof_neg),
    .det_mag (det_mag),
    .det_neg (det_neg)
  );

  for (genvar k = 0; k < 9; k++) begin : g_lane
    m3i_pkg::ctrl_t c_out;
    m3i_div_lane #(.W(W), .F(FRAC_BITS)) u_lane (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .ctrl_in  (fctrl),
      .cof_mag  (cof_mag[k]),
      .cof_neg  (cof_neg[k]),
      .det_mag  (det_mag),
      .det_neg  (det_neg),
      .ctrl_out (c_out),
      .val      (lval[k]),
      .sat      (lsat[k])
    );
    if (k == 0) begin : g_ctl
      assign lctrl = c_out;
    end
  end

  // merge: singular forces zeros and clears saturation, else saturation is the or of all lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= lctrl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      singular  <= lctrl.singular;
      saturated <= !lctrl.singular && (lsat[0] || lsat[1] || lsat[2] || lsat[3] || lsat[4]
                   || lsat[5] || lsat[6] || lsat[7] || lsat[8]);
      for (int k = 0; k < 9; k++) res[k] <= lctrl.singular ? '0 : lval[k];
    end
  end

  assign inv_r0c0 = res[0];
  assign inv_r1c0 = res[1];
  assign inv_r2c0 = res[2];
  assign inv_r0c1 = res[3];
  assign inv_r1c1 = res[4];
  assign inv_r2c1 = res[5];
  assign inv_r0c2 = res[6];
  assign inv_r1c2 = res[7];
  assign inv_r2c2 = res[8];

  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && singular |-> !saturated && inv_r0c0 == '0 && inv_r1c1 == '0
                               && inv_r2c2 == '0)
    else $error("singular result not cleared");

  a_stall_back: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while output stalled");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(saturated))
    else $error("stalled result changed");

endmodule
